[rtl/tca_pkg.sv]
package tca_pkg;

  // event kinds carried on the input tuser
  localparam logic [1:0] EV_TICK   = 2'd0;
  localparam logic [1:0] EV_EXPIRY = 2'd1;
  localparam logic [1:0] EV_START  = 2'd2;

  // calibration status codes
  localparam logic [1:0] ST_ONGOING = 2'd0;
  localparam logic [1:0] ST_SUCCESS = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  localparam int unsigned STAGE_W   = 10;
  localparam int unsigned TIMER_W   = 32;
  localparam int unsigned CYCLE_W   = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_DATA_W = 96;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_PAD_W = OUT_DATA_W - STATUS_W - TIMER_W - CYCLE_W;

  localparam logic [STAGE_W-1:0] STAGES_AT_RESET = 10'd100;

  // request from the sequencer to the shared divider
  typedef struct packed {
    logic start;
    logic narrow;  // 32 quotient bits instead of 64
  } div_req_t;

endpackage

[rtl/tca_div.sv]
module tca_div (
  input  logic                           clk,
  input  logic                           rst,
  input  tca_pkg::div_req_t              req,
  input  logic [tca_pkg::CYCLE_W-1:0]    dividend,
  input  logic [tca_pkg::STAGE_W-1:0]    divisor,
  output logic                           done,
  output logic [tca_pkg::CYCLE_W-1:0]    quotient
);
  import tca_pkg::*;

  logic                 busy;
  logic [5:0]           cnt;
  logic [STAGE_W-1:0]   rem;
  logic [CYCLE_W-1:0]   quo;
  logic [STAGE_W:0]     trial;
  logic                 fits;
  logic [STAGE_W-1:0]   rem_next;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem, quo[CYCLE_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? STAGE_W'(trial - {1'b0, divisor}) : trial[STAGE_W-1:0];
  end

  // step counter and busy/done flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.narrow ? 6'd31 : 6'd63;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  // datapath, quotient bits enter from the bottom msb first
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[CYCLE_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[rtl/timer_calibration_averager.sv]
// start, expiry and counting ticks pass from acceptance to S_DONE and then to the output
// register, which loads once the output is free; an averaging tick runs 64 steps of the
// shared radix-2 divider for the cycle average, then 32 steps for the timer average
// throughput: one event at a time, tready is high only while the sequencer is idle
// reset: synchronous active-high rst clears stage, status, captures and averages to 0
// and sets total_stages to 100
module timer_calibration_averager (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tca_pkg::STAGE_W-1:0]       cfg_wr_data,   // total_stages
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tca_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // timer_count, cycle_count
  input  logic [1:0]                        s_axis_tuser,  // func
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tca_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // status, avg_timer_ticks,
                                                           // avg_cycles, zero pad
);
  import tca_pkg::*;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DIV_CYC = 2'd1;
  localparam logic [1:0] S_DIV_TMR = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]          state;
  logic [STAGE_W-1:0]  total_stages;
  logic [STAGE_W-1:0]  stage;
  logic [1:0]          cal_status;
  logic [TIMER_W-1:0]  first_timer;
  logic [CYCLE_W-1:0]  first_cycles;
  logic [TIMER_W-1:0]  avg_timer;
  logic [CYCLE_W-1:0]  avg_cyc;
  logic [TIMER_W-1:0]  dt_hold;

  logic                s_accept;
  logic [TIMER_W-1:0]  in_timer;
  logic [CYCLE_W-1:0]  in_cycles;
  logic                avg_tick;
  logic [CYCLE_W-1:0]  dc;

  div_req_t            div_req;
  logic [CYCLE_W-1:0]  div_dividend;
  logic                div_done;
  logic [CYCLE_W-1:0]  div_quo;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_timer      = s_axis_tdata[TIMER_W-1:0];
  assign in_cycles     = s_axis_tdata[TIMER_W +: CYCLE_W];
  assign avg_tick      = (s_axis_tuser == EV_TICK) && (stage >= total_stages);
  assign dc            = in_cycles - first_cycles;

  // divider requests: cycle average first, timer average after it
  always_comb begin
    div_req.start  = (s_accept && avg_tick) || ((state == S_DIV_CYC) && div_done);
    div_req.narrow = (state == S_DIV_CYC);
    div_dividend   = (state == S_IDLE) ? dc : {dt_hold, {TIMER_W{1'b0}}};
  end

  tca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (total_stages),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_stages <= STAGES_AT_RESET;
    end else if (cfg_wr_en) begin
      total_stages <= cfg_wr_data;
    end
  end

  // sequencer and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stage        <= '0;
      cal_status   <= ST_ONGOING;
      first_timer  <= '0;
      first_cycles <= '0;
      avg_timer    <= '0;
      avg_cyc      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= S_DONE;
            case (s_axis_tuser)
              EV_TICK: begin
                if (avg_tick) begin
                  state   <= S_DIV_CYC;
                  dt_hold <= first_timer - in_timer;
                  if (cal_status == ST_ONGOING) begin
                    cal_status <= ST_SUCCESS;
                  end
                end else begin
                  if (stage == '0) begin
                    first_timer  <= in_timer;
                    first_cycles <= in_cycles;
                  end
                  stage <= stage + STAGE_W'(1);
                end
              end
              EV_EXPIRY: begin
                if (cal_status == ST_ONGOING) begin
                  cal_status <= ST_FAILED;
                end
              end
              EV_START: begin
                stage      <= '0;
                cal_status <= ST_ONGOING;
              end
              default: ;
            endcase
          end
        end
        S_DIV_CYC: begin
          if (div_done) begin
            avg_cyc <= div_quo;
            state   <= S_DIV_TMR;
          end
        end
        S_DIV_TMR: begin
          if (div_done) begin
            avg_timer <= div_quo[TIMER_W-1:0];
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, avg_cyc, avg_timer, cal_status};
    end
  end

  // checks
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_CYC || state == S_DIV_TMR))
    else $error("divider finished outside a divide phase");

  a_short_event: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !avg_tick) |=> (state == S_DONE))
    else $error("non-averaging event did not go straight to output");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    cal_status != 2'd3)
    else $error("calibration status holds an unused code");

  a_avg_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s_accept && avg_tick) |=> (state == S_DIV_CYC && !div_done))
    else $error("averaging tick did not start the cycle divide");

endmodule
